>>> rtl/bfa_pkg.sv
package bfa_pkg;

  // Width of the chunk size needed by a request, header unit included.
  localparam int NEED_W = 14;

  // Width of the 16-bit request and offset fields.
  localparam int REQ_W = 16;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    STAT_ALLOCATED = 3'd0,
    STAT_NO_FIT    = 3'd1,
    STAT_FREED     = 3'd2,
    STAT_NULL_FREE = 3'd3,
    STAT_BAD_PTR   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_WALK,
    ST_A_FIT,
    ST_A_MARK,
    ST_F_HDR,
    ST_F_NEXT,
    ST_F_CLRN,
    ST_F_WALK,
    ST_F_PREV,
    ST_F_CLRH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] payload;
    logic [12:0] bytes;
    logic [9:0]  blocks;
  } res_t;

endpackage

>>> rtl/best_fit_heap_allocator.sv
// Best-fit heap allocator over a heap of HEAP_BYTES bytes, kept as an implicit
// list of chunk headers (allocated flag plus size in 8-byte units) in one
// synchronous header memory of HEAP_BYTES/8 entries.
// Input channel (in_valid_i/in_ready_o): one beat is an allocate or free
// request. Output channel (out_valid_o/out_ready_i): one beat per request with
// status, granted payload offset and running totals of held bytes and blocks.
// After reset the header memory is swept once, one entry per cycle, with
// in_ready_o held low during the sweep; entry zero then covers the
// whole heap and the totals read zero.
// An allocate walks the whole list, one header read per cycle on the memory
// read port, then marks the best fit, splitting off any remainder. A free reads
// the freed header, may absorb a free next chunk, then walks the chunks that lie
// before the freed one, at least one (previous-chunk walk), to merge with a free
// previous chunk. Null and malformed frees answer straight from idle, a free
// that names no allocated header once that header is read. One request is in
// flight at a time. Results land in an output register, so the next request is
// taken while a finished beat still waits on a stalled receiver; a second
// result holds inside the engine until that register drains.
module best_fit_heap_allocator #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [15:0]        request_bytes_i,
  input  logic               pointer_null_i,
  input  logic signed [15:0] payload_offset_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [11:0]        payload_offset_out_o,
  output logic [12:0]        outstanding_bytes_o,
  output logic [9:0]         outstanding_blocks_o
);

  import bfa_pkg::*;

  localparam int Units = HEAP_BYTES / 8;
  localparam int IW    = $clog2(Units);
  localparam int EW    = $clog2(Units + 1) + 1;

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic          out_valid_q, out_valid_d;
  res_t          out_q;

  // Header memory: one write and one registered read per cycle.
  bfa_ram #(
    .WIDTH (EW),
    .DEPTH (Units)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer: list walks, split, coalesce and running totals.
  bfa_engine #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_engine (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .request_bytes_i     (request_bytes_i),
    .pointer_null_i      (pointer_null_i),
    .payload_offset_in_i (payload_offset_in_i),
    .res_valid_o         (res_valid),
    .res_ready_i         (res_ready),
    .res_o               (res),
    .raddr_o             (raddr),
    .rdata_i             (rdata),
    .we_o                (we),
    .waddr_o             (waddr),
    .wdata_o             (wdata)
  );

  // Output register: load when empty or when the current beat leaves.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload holds while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_q.status;
  assign payload_offset_out_o = out_q.payload;
  assign outstanding_bytes_o  = out_q.bytes;
  assign outstanding_blocks_o = out_q.blocks;

endmodule

>>> rtl/bfa_ram.sv
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bfa_engine.sv
module bfa_engine #(
  parameter int HEAP_BYTES = 4096,
  localparam int Units = HEAP_BYTES / 8,
  localparam int IW = $clog2(Units),
  localparam int SW = $clog2(Units + 1),
  localparam int EW = SW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [15:0]        request_bytes_i,
  input  logic               pointer_null_i,
  input  logic signed [15:0] payload_offset_in_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output bfa_pkg::res_t      res_o,
  output logic [IW-1:0]      raddr_o,
  input  logic [EW-1:0]      rdata_i,
  output logic               we_o,
  output logic [IW-1:0]      waddr_o,
  output logic [EW-1:0]      wdata_o
);

  import bfa_pkg::*;

  localparam int PW = IW + 1;
  localparam int BW = $clog2(HEAP_BYTES + 1);
  localparam int CW = $clog2(Units + 1);

  state_e            state_q, state_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [IW-1:0]     best_q, best_d;
  logic [SW-1:0]     best_sz_q, best_sz_d;
  logic              found_q, found_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [IW-1:0]     h_q, h_d;
  logic [IW-1:0]     nx_q, nx_d;
  logic [SW-1:0]     s_q, s_d;
  logic              prev_free_q, prev_free_d;
  logic [SW-1:0]     prev_sz_q, prev_sz_d;
  status_e           status_q, status_d;
  logic [11:0]       payload_q, payload_d;
  logic [BW-1:0]     bytes_q, bytes_d;
  logic [CW-1:0]     blocks_q, blocks_d;
  logic [IW-1:0]     clr_q, clr_d;

  logic              rd_used;
  logic [SW-1:0]     rd_size;
  logic [SW-1:0]     rd_units;
  logic [BW-1:0]     rd_bytes;
  logic [PW-1:0]     walk_next;
  logic              fit;
  logic [REQ_W:0]    req_round;
  logic [NEED_W-1:0] req_units;
  logic [NEED_W-1:0] need_in;
  logic signed [REQ_W+1:0] hdr_off;
  logic              bad_ptr;
  logic [PW-1:0]     nx_calc;
  logic [NEED_W:0]   split_end;
  logic [IW+3:0]     grant_off;

  // Header word: top bit marks an allocated chunk, the rest is the size in units.
  assign rd_used   = rdata_i[SW];
  assign rd_size   = rdata_i[SW-1:0];
  assign rd_units  = (rd_size == '0) ? SW'(1) : rd_size;
  assign rd_bytes  = BW'({rd_units, 3'b000});
  assign walk_next = pos_q + PW'(rd_units);
  assign fit = !rd_used && (NEED_W'(rd_units) >= need_q) &&
               (!found_q || (rd_units < best_sz_q));

  // Round up to 8 bytes; a zero request counts as one unit.
  assign req_round = {1'b0, request_bytes_i} + (REQ_W + 1)'(7);
  assign req_units = req_round[REQ_W:3];
  assign need_in   = ((req_units == '0) ? NEED_W'(1) : req_units) + NEED_W'(1);

  assign hdr_off = (REQ_W + 2)'(payload_offset_in_i) - (REQ_W + 2)'(8);
  assign bad_ptr = (payload_offset_in_i[2:0] != 3'd0) || hdr_off[REQ_W+1] ||
                   (hdr_off[REQ_W:0] >= (REQ_W + 1)'(HEAP_BYTES));

  assign nx_calc   = PW'(h_q) + PW'(rd_units);
  assign split_end = (NEED_W + 1)'(best_q) + (NEED_W + 1)'(need_q);
  assign grant_off = {(IW + 1)'(best_q) + (IW + 1)'(1), 3'b000};

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    best_d      = best_q;
    best_sz_d   = best_sz_q;
    found_d     = found_q;
    need_d      = need_q;
    h_d         = h_q;
    nx_d        = nx_q;
    s_d         = s_q;
    prev_free_d = prev_free_q;
    prev_sz_d   = prev_sz_q;
    status_d    = status_q;
    payload_d   = payload_q;
    bytes_d     = bytes_q;
    blocks_d    = blocks_q;
    clr_d       = clr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    raddr_o     = pos_q[IW-1:0];
    we_o        = 1'b0;
    waddr_o     = h_q;
    wdata_o     = '0;

    case (state_q)
      ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = (clr_q == '0) ? {1'b0, SW'(Units)} : '0;
        clr_d   = clr_q + IW'(1);
        if (clr_q == IW'(Units - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        raddr_o    = '0;
        if (in_valid_i) begin
          payload_d = '0;
          if (kind_i == KIND_ALLOC) begin
            need_d  = need_in;
            pos_d   = '0;
            found_d = 1'b0;
            state_d = ST_A_WALK;
          end else if (pointer_null_i) begin
            status_d = STAT_NULL_FREE;
            state_d  = ST_DONE;
          end else if (bad_ptr) begin
            status_d = STAT_BAD_PTR;
            state_d  = ST_DONE;
          end else begin
            h_d     = hdr_off[IW+2:3];
            raddr_o = hdr_off[IW+2:3];
            state_d = ST_F_HDR;
          end
        end
      end

      ST_A_WALK: begin
        if (fit) begin
          found_d   = 1'b1;
          best_d    = pos_q[IW-1:0];
          best_sz_d = rd_units;
        end
        pos_d   = walk_next;
        raddr_o = walk_next[IW-1:0];
        if (walk_next >= PW'(Units)) begin
          state_d = ST_A_FIT;
        end
      end

      ST_A_FIT: begin
        if (!found_q) begin
          status_d = STAT_NO_FIT;
          state_d  = ST_DONE;
        end else begin
          if ((NEED_W'(best_sz_q) > need_q) && (split_end < (NEED_W + 1)'(Units))) begin
            we_o      = 1'b1;
            waddr_o   = best_q + IW'(need_q);
            wdata_o   = {1'b0, best_sz_q - SW'(need_q)};
            best_sz_d = SW'(need_q);
          end
          state_d = ST_A_MARK;
        end
      end

      ST_A_MARK: begin
        we_o      = 1'b1;
        waddr_o   = best_q;
        wdata_o   = {1'b1, best_sz_q};
        bytes_d   = bytes_q + BW'({best_sz_q, 3'b000});
        blocks_d  = blocks_q + CW'(1);
        status_d  = STAT_ALLOCATED;
        payload_d = 12'(grant_off);
        state_d   = ST_DONE;
      end

      ST_F_HDR: begin
        if (!rd_used) begin
          status_d = STAT_BAD_PTR;
          state_d  = ST_DONE;
        end else begin
          s_d      = rd_units;
          bytes_d  = (bytes_q >= rd_bytes) ? bytes_q - rd_bytes : '0;
          blocks_d = (blocks_q != '0) ? blocks_q - CW'(1) : '0;
          we_o     = 1'b1;
          waddr_o  = h_q;
          wdata_o  = {1'b0, rd_units};
          nx_d     = nx_calc[IW-1:0];
          if (nx_calc < PW'(Units)) begin
            raddr_o = nx_calc[IW-1:0];
            state_d = ST_F_NEXT;
          end else begin
            pos_d   = '0;
            raddr_o = '0;
            state_d = ST_F_WALK;
          end
        end
      end

      ST_F_NEXT: begin
        if (!rd_used) begin
          // Absorb the free chunk that follows.
          s_d     = s_q + rd_units;
          we_o    = 1'b1;
          waddr_o = h_q;
          wdata_o = {1'b0, s_q + rd_units};
          state_d = ST_F_CLRN;
        end else begin
          pos_d   = '0;
          raddr_o = '0;
          state_d = ST_F_WALK;
        end
      end

      ST_F_CLRN: begin
        we_o    = 1'b1;
        waddr_o = nx_q;
        pos_d   = '0;
        raddr_o = '0;
        state_d = ST_F_WALK;
      end

      ST_F_WALK: begin
        // Advance until the chunk whose end reaches the freed header.
        if (walk_next < PW'(h_q)) begin
          pos_d   = walk_next;
          raddr_o = walk_next[IW-1:0];
        end else begin
          prev_free_d = !rd_used;
          prev_sz_d   = rd_units;
          state_d     = ST_F_PREV;
        end
      end

      ST_F_PREV: begin
        if ((pos_q != PW'(h_q)) && prev_free_q) begin
          we_o    = 1'b1;
          waddr_o = pos_q[IW-1:0];
          wdata_o = {1'b0, prev_sz_q + s_q};
          state_d = ST_F_CLRH;
        end else begin
          status_d = STAT_FREED;
          state_d  = ST_DONE;
        end
      end

      ST_F_CLRH: begin
        we_o     = 1'b1;
        waddr_o  = h_q;
        status_d = STAT_FREED;
        state_d  = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      bytes_q  <= '0;
      blocks_q <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      bytes_q  <= bytes_d;
      blocks_q <= blocks_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    best_q      <= best_d;
    best_sz_q   <= best_sz_d;
    need_q      <= need_d;
    h_q         <= h_d;
    nx_q        <= nx_d;
    s_q         <= s_d;
    prev_free_q <= prev_free_d;
    prev_sz_q   <= prev_sz_d;
    status_q    <= status_d;
    payload_q   <= payload_d;
  end

  assign res_o.status  = status_q;
  assign res_o.payload = payload_q;
  assign res_o.bytes   = 13'(bytes_q);
  assign res_o.blocks  = 10'(blocks_q);

endmodule

>>> rtl/bfa_checker.sv
module bfa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               kind_i,
  input logic [15:0]        request_bytes_i,
  input logic               pointer_null_i,
  input logic signed [15:0] payload_offset_in_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         status_o,
  input logic [11:0]        payload_offset_out_o,
  input logic [12:0]        outstanding_bytes_o,
  input logic [9:0]         outstanding_blocks_o
);

  import bfa_pkg::*;

  // Only defined result codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_ALLOCATED) || (status_o == STAT_NO_FIT) ||
                    (status_o == STAT_FREED) || (status_o == STAT_NULL_FREE) ||
                    (status_o == STAT_BAD_PTR))
  else $error("undefined status code");

  // A non-grant carries no offset; a grant is 8-byte aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_ALLOCATED)) |-> (payload_offset_out_o == 12'd0))
  else $error("offset on a non-grant result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (payload_offset_out_o[2:0] == 3'd0) && (outstanding_bytes_o[2:0] == 3'd0))
  else $error("misaligned offset or byte total");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(payload_offset_out_o) &&
       $stable(outstanding_bytes_o) && $stable(outstanding_blocks_o)))
  else $error("result beat changed under stall");

  // A waiting request beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(kind_i) && $stable(request_bytes_i) &&
       $stable(pointer_null_i) && $stable(payload_offset_in_i)))
  else $error("request beat changed under stall");

endmodule

bind best_fit_heap_allocator bfa_checker u_bfa_checker (.*);

>>> sim/best_fit_heap_allocator_test.sv
`timescale 1ns / 1ps

module best_fit_heap_allocator_test;
  import bfa_pkg::*;

  localparam int          HEAP_BYTES = 4096;
  localparam int          HEAP_UNITS = HEAP_BYTES / 8;
  localparam int          RANDOM_BEATS = 800;
  // Slowest run: ~830 beats, each a full list walk plus stalls and gaps,
  // after the clearing sweep; take it several times over.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          DRAIN_CYCLES = 600;

  localparam logic [15:0] USED_FLAG = 16'h8000;
  localparam logic [15:0] SIZE_BITS = 16'h7FFF;

  // Shadow of the header memory and the running totals. Every accepted
  // request beat is replayed here and its result queued for comparison.
  class heap_scoreboard;
    logic [15:0]  hdr[HEAP_UNITS];
    int unsigned  held_bytes;
    int unsigned  held_blocks;
    res_t         awaited_q[$];
    int           granted_q[$];   // payload offsets currently allocated
    int unsigned  mismatches;

    function new();
      foreach (hdr[i]) hdr[i] = '0;
      hdr[0] = 16'(HEAP_UNITS) & SIZE_BITS;
      held_bytes = 0;
      held_blocks = 0;
      mismatches = 0;
    endfunction

    // An all-zero header still advances the walk by one unit.
    function int unsigned units(int unsigned idx);
      int unsigned s;
      s = int'(hdr[idx] & SIZE_BITS);
      return (s == 0) ? 1 : s;
    endfunction

    function bit used(int unsigned idx);
      return hdr[idx][15];
    endfunction

    function res_t outcome(status_e st, int unsigned pay);
      res_t r;
      r.status = st;
      r.payload = 12'(pay);
      r.bytes = 13'(held_bytes);
      r.blocks = 10'(held_blocks);
      return r;
    endfunction

    function res_t grant(int unsigned req);
      int unsigned bytes, need, pos, best, best_sz, n, s;
      bit          found;
      bytes = (req + 7) & ~32'd7;
      if (bytes == 0) bytes = 8;
      need = bytes / 8 + 1;
      pos = 0;
      best = 0;
      best_sz = 0;
      found = 1'b0;
      for (n = 0; n < HEAP_UNITS && pos < HEAP_UNITS; n++) begin
        s = units(pos);
        if (!used(pos) && s >= need && (!found || s < best_sz)) begin
          found = 1'b1;
          best = pos;
          best_sz = s;
        end
        pos += s;
      end
      if (!found) return outcome(STAT_NO_FIT, 0);
      if (best_sz >= need + 1 && best + need < HEAP_UNITS) begin
        hdr[best + need] = 16'(best_sz - need) & SIZE_BITS;
        best_sz = need;
      end
      hdr[best] = (16'(best_sz) & SIZE_BITS) | USED_FLAG;
      held_bytes += best_sz * 8;
      held_blocks += 1;
      granted_q.push_back((best + 1) * 8);
      return outcome(STAT_ALLOCATED, (best + 1) * 8);
    endfunction

    function res_t reclaim(logic signed [15:0] raw);
      int          off, hb;
      int unsigned h, s, nx, p, n;
      off = int'(raw);
      hb = off - 8;
      if (raw[2:0] != 3'd0 || hb < 0 || hb >= HEAP_BYTES) return outcome(STAT_BAD_PTR, 0);
      h = hb / 8;
      if (!used(h)) return outcome(STAT_BAD_PTR, 0);
      s = units(h);
      held_bytes = (held_bytes >= s * 8) ? held_bytes - s * 8 : 0;
      held_blocks = (held_blocks > 0) ? held_blocks - 1 : 0;
      hdr[h] = 16'(s) & SIZE_BITS;
      // Merge with a free next chunk first, then with a free previous one.
      nx = h + s;
      if (nx < HEAP_UNITS && !used(nx)) begin
        s += units(nx);
        hdr[h] = 16'(s) & SIZE_BITS;
        hdr[nx] = '0;
      end
      p = 0;
      for (n = 0; n < HEAP_UNITS && p + units(p) < h; n++) p += units(p);
      if (p != h && p < HEAP_UNITS && !used(p)) begin
        hdr[p] = 16'(units(p) + s) & SIZE_BITS;
        hdr[h] = '0;
      end
      foreach (granted_q[i]) begin
        if (granted_q[i] == off) begin
          granted_q.delete(i);
          break;
        end
      end
      return outcome(STAT_FREED, 0);
    endfunction

    function void note_request(kind_e kind, logic [15:0] req, logic is_null,
                               logic signed [15:0] off);
      if (kind == KIND_ALLOC) awaited_q.push_back(grant(int'(req)));
      else if (is_null) awaited_q.push_back(outcome(STAT_NULL_FREE, 0));
      else awaited_q.push_back(reclaim(off));
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [2:0] st, logic [11:0] pay, logic [12:0] by, logic [9:0] bl);
      res_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d payload=%0d", st, pay));
        return;
      end
      want = awaited_q.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (pay !== want.payload)
        report($sformatf("payload offset %0d, want %0d", pay, want.payload));
      if (by !== want.bytes)
        report($sformatf("outstanding bytes %0d, want %0d", by, want.bytes));
      if (bl !== want.blocks)
        report($sformatf("outstanding blocks %0d, want %0d", bl, want.blocks));
    endtask
  endclass

  // Drive every input to a known value from time zero.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               kind_i = 1'b0;
  logic [15:0]        request_bytes_i = '0;
  logic               pointer_null_i = 1'b0;
  logic signed [15:0] payload_offset_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [11:0]        payload_offset_out_o;
  logic [12:0]        outstanding_bytes_o;
  logic [9:0]         outstanding_blocks_o;

  heap_scoreboard sb = new();
  bit             calm = 1'b0;   // set for a stretch with no idling on either side
  int unsigned    cycles = 0;

  best_fit_heap_allocator #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .request_bytes_i     (request_bytes_i),
    .pointer_null_i      (pointer_null_i),
    .payload_offset_in_i (payload_offset_in_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .payload_offset_out_o(payload_offset_out_o),
    .outstanding_bytes_o (outstanding_bytes_o),
    .outstanding_blocks_o(outstanding_blocks_o)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: check each accepted beat, then throttle ready for the next edge.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result(status_o, payload_offset_out_o, outstanding_bytes_o,
                      outstanding_blocks_o);
    out_ready_i <= calm || ($urandom_range(99) >= 30);
  end

  // Drop valid for a random number of cycles, unless in the calm stretch.
  task idle_input();
    if (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
  endtask

  // Present one request beat and hold it until accepted, then predict it.
  task send(kind_e kind, logic [15:0] req, logic is_null, logic signed [15:0] off);
    idle_input();
    in_valid_i <= 1'b1;
    kind_i <= kind;
    request_bytes_i <= req;
    pointer_null_i <= is_null;
    payload_offset_in_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(kind, req, is_null, off);
  endtask

  task alloc_beat(logic [15:0] req);
    send(KIND_ALLOC, req, 1'($urandom), 16'($urandom));
  endtask

  task free_beat(logic signed [15:0] off);
    send(KIND_FREE, 16'($urandom), 1'b0, off);
  endtask

  // One random beat, shaped by how many chunks are live so that the heap
  // fragments and recombines instead of filling up or staying empty.
  task random_beat();
    int          live, pick, sel, share;
    logic [15:0] req;
    live = sb.granted_q.size();
    share = (live < 3) ? 75 : (live > 30) ? 30 : 50;
    if ($urandom_range(99) < share) begin
      sel = $urandom_range(99);
      if (sel < 70) req = 16'($urandom_range(64, 0));
      else if (sel < 90) req = 16'($urandom_range(512, 65));
      else if (sel < 97) req = 16'($urandom_range(4096, 513));
      else req = 16'($urandom);
      alloc_beat(req);
    end else begin
      sel = $urandom_range(99);
      if (sel < 80 && live > 0) begin
        pick = $urandom_range(live - 1);
        free_beat(16'(sb.granted_q[pick]));
      end else if (sel < 88) begin
        send(KIND_FREE, 16'($urandom), 1'b1, 16'($urandom));
      end else if (sel < 94) begin
        // Aligned, often lands on a free header or inside a payload.
        free_beat(16'(8 * $urandom_range(HEAP_UNITS + 1)));
      end else if (sel < 97 && live > 0) begin
        pick = $urandom_range(live - 1);
        free_beat(16'(sb.granted_q[pick] + $urandom_range(7, 1)));
      end else begin
        free_beat(16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero, tiny and split allocations, then fits that fail.
    alloc_beat(16'd0);
    alloc_beat(16'd1);
    alloc_beat(16'd16);
    alloc_beat(16'hFFFF);
    alloc_beat(16'd4089);
    send(KIND_FREE, 16'($urandom), 1'b1, 16'($urandom));
    // Malformed frees: unaligned, negative, outside, inside a payload.
    free_beat(16'sh7FFF);
    free_beat(-16'sd32768);
    free_beat(16'sd4104);
    free_beat(16'sd16);
    // Free with no merge, double free, merge with next, merge both sides.
    free_beat(16'sd24);
    free_beat(16'sd24);
    free_beat(16'sd8);
    free_beat(16'sd40);
    // Exact fit of the whole heap, full heap, back to empty.
    alloc_beat(16'd4088);
    alloc_beat(16'd0);
    free_beat(16'sd8);
    // Best fit must pick the small hole over the large tail.
    alloc_beat(16'd8);
    alloc_beat(16'd40);
    alloc_beat(16'd8);
    alloc_beat(16'd16);
    free_beat(16'sd24);
    free_beat(16'sd88);
    alloc_beat(16'd24);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= 300 && i < 450);
      random_beat();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then give a stray late beat time to show up.
    while (sb.awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
